// ----- hdl/lphm_pkg.sv -----
package lphm_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hff51afd7ed558ccd;
  localparam int          MIX_SHIFT = 33;
  localparam int          COUNT_W   = 11;

  typedef enum logic [1:0] {
    ACT_PUT = 2'd0,
    ACT_GET = 2'd1,
    ACT_HAS = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    action_t            action;
    logic signed [63:0] key;
    logic signed [63:0] value;
  } in_t;

  typedef struct packed {
    logic signed [63:0]  result_value;
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;
  } out_t;

endpackage

// ----- hdl/lphm_mix_unit.sv -----
module lphm_mix_unit #(
  parameter int SLOT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          key,
  output logic                 done,
  output logic [SLOT_BITS-1:0] home
);

  localparam logic [31:0] MUL_LO = lphm_pkg::MIX_MUL[31:0];
  localparam logic [31:0] MUL_HI = lphm_pkg::MIX_MUL[63:32];

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LL   = 5'b00010,
    M_HL   = 5'b00100,
    M_LH   = 5'b01000,
    M_SUM  = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] h1_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mix_sum;
  logic [63:0] mix;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      M_IDLE: if (start) phase_nxt = M_LL;
      M_LL:   phase_nxt = M_HL;
      M_HL:   phase_nxt = M_LH;
      M_LH:   phase_nxt = M_SUM;
      M_SUM:  phase_nxt = M_IDLE;
      default: phase_nxt = M_IDLE;
    endcase
  end

  // one 32x32 multiplier: lo*lo, hi*lo, lo*hi (low 64 bits of the product)
  assign mul_a = (phase_r == M_HL) ? h1_r[63:32] : h1_r[31:0];
  assign mul_b = (phase_r == M_LH) ? MUL_HI : MUL_LO;
  assign mul_p = mul_a * mul_b;

  assign mix_sum = acc_r + {prod_r[31:0], 32'd0};
  assign mix     = mix_sum ^ (mix_sum >> lphm_pkg::MIX_SHIFT);
  assign home    = mix[SLOT_BITS-1:0];
  assign done    = (phase_r == M_SUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= M_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == M_IDLE && start) begin
      h1_r <= key ^ (key >> lphm_pkg::MIX_SHIFT);
    end
    prod_r <= mul_p;
    if (phase_r == M_HL) begin
      acc_r <= prod_r;
    end else if (phase_r == M_LH) begin
      acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
    end
  end

endmodule

// ----- hdl/linear_probe_hash_map.sv -----
// Open-addressed key/value table with linear probing, 64-bit keys and values.
// Input channel (in_valid/in_stall/in_data) takes one beat per operation:
// put, get, contains, or a no-op. Output channel (out_valid/out_stall/out_data)
// returns one beat per operation with value, status and occupied count.
// An operation hashes the key on one shared 32x32 multiplier, then probes
// the slots in turn (registered read of the slot memory, then compare) until
// it finds the key or an empty slot or has probed every slot. The result beat
// is held in an output register; a no-op goes straight to it without hashing.
// in_stall is low only while the block is idle, so a new beat is taken as the
// previous result is shown.
// A put of a new key is refused with status full once half the slots are used.
// After reset the block clears the occupied flags of all TABLE_SLOTS slots,
// one slot per cycle, and keeps in_stall high meanwhile.
// When out_stall is high the result beat is held in the output register; the
// block may take and work on the next beat, and waits before its result.
module linear_probe_hash_map #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lphm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lphm_pkg::out_t out_data
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int XW = (IW > lphm_pkg::COUNT_W) ? IW : lphm_pkg::COUNT_W;
  localparam logic [IW-1:0] SLOT_LAST  = IW'(TABLE_SLOTS - 1);
  localparam logic [IW-1:0] HALF_SLOTS = IW'(TABLE_SLOTS / 2);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic        occ;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

  slot_t mem [TABLE_SLOTS];
  slot_t rd_r;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        clr_idx_r, clr_idx_nxt;
  logic [IW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lphm_pkg::out_t       out_data_r, out_data_nxt;
  lphm_pkg::action_t    act_r, act_nxt;
  logic [63:0]          key_r, key_nxt;
  logic [63:0]          val_r, val_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        home_r, home_nxt;
  logic [63:0]          res_r, res_nxt;
  lphm_pkg::status_t    st_r, st_nxt;

  logic          mix_start;
  logic          mix_done;
  logic [IW-1:0] mix_home;
  logic          hit;
  logic [IW-1:0] idx_inc;
  logic [XW-1:0] cnt_ext;

  lphm_mix_unit #(
    .SLOT_BITS (IW)
  ) u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mix_start),
    .key   (in_data.key),
    .done  (mix_done),
    .home  (mix_home)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hit     = rd_r.occ && (rd_r.key == key_r);
  assign idx_inc = idx_r + 1'b1;
  assign cnt_ext = XW'(count_r);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    home_nxt      = home_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '{occ: 1'b1, key: key_r, value: val_r};
    mix_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_data.action;
          key_nxt = in_data.key;
          val_nxt = in_data.value;
          res_nxt = '0;
          st_nxt  = lphm_pkg::ST_OK;
          if (in_data.action == lphm_pkg::ACT_NOP) begin
            state_nxt = S_DONE;
          end else begin
            mix_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mix_done) begin
          idx_nxt   = mix_home;
          home_nxt  = mix_home;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_r.occ || hit || idx_inc == home_r) begin
          state_nxt = S_DONE;
          unique case (act_r)
            lphm_pkg::ACT_PUT: begin
              if (hit) begin
                wr_en = 1'b1;
              end else if (count_r >= HALF_SLOTS || rd_r.occ) begin
                st_nxt = lphm_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            lphm_pkg::ACT_GET: begin
              if (hit) begin
                res_nxt = rd_r.value;
              end else begin
                st_nxt = lphm_pkg::ST_MISS;
              end
            end
            lphm_pkg::ACT_HAS: begin
              if (!hit) begin
                st_nxt = lphm_pkg::ST_MISS;
              end
            end
            lphm_pkg::ACT_NOP: begin
            end
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_value: res_r, status: st_r,
                            entry_count: cnt_ext[lphm_pkg::COUNT_W-1:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    home_r     <= home_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_r == S_READ) begin
      rd_r <= mem[idx_r];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HALF_SLOTS)
    else $error("occupied count above half the slots");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  a_mix_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    mix_done |-> state_r == S_HASH)
    else $error("hash result outside the hash phase");

  a_fill_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && wr_data.occ |-> state_r == S_CHECK)
    else $error("slot filled outside the compare step");

endmodule

// ----- tb/linear_probe_hash_map_tb.sv -----
module linear_probe_hash_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 1024;
  localparam int RANDOM_BEATS = 950;
  localparam int SETTLE_CYCLES = 6 + 2 * (TABLE_SLOTS / 2 + 1) + 64;

  class kv_table_tracker #(int SLOTS = 1024);
    logic [63:0]    slot_key [SLOTS];
    logic [63:0]    slot_val [SLOTS];
    bit             slot_used [SLOTS];
    int unsigned    used_count;
    lphm_pkg::out_t expected_replies [$];
    int unsigned    errors;
    int unsigned    n_put, n_get, n_has, n_nop, n_full, n_miss, n_checked;
    int unsigned    longest_probe;

    function int unsigned home_of(logic [63:0] k);
      logic [63:0] h;
      h = k ^ (k >> lphm_pkg::MIX_SHIFT);
      h = h * lphm_pkg::MIX_MUL;
      h = h ^ (h >> lphm_pkg::MIX_SHIFT);
      return h[31:0] & (SLOTS - 1);
    endfunction

    function bit find_slot(logic [63:0] k, output int unsigned at, output bit empty,
                           output int unsigned steps);
      int unsigned idx;
      idx = home_of(k);
      at = 0;
      empty = 1'b0;
      for (steps = 1; steps <= SLOTS; steps++) begin
        if (!slot_used[idx]) begin
          at = idx;
          empty = 1'b1;
          return 1'b0;
        end
        if (slot_key[idx] == k) begin
          at = idx;
          return 1'b1;
        end
        idx = (idx + 1) % SLOTS;
      end
      return 1'b0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] ERROR %s", $time, what);
    endtask

    task note_request(lphm_pkg::in_t beat);
      lphm_pkg::out_t reply;
      int unsigned    at, steps;
      bit             hit, empty;
      logic [63:0]    k;
      k = beat.key;
      reply = '0;
      reply.status = lphm_pkg::ST_OK;
      hit = 1'b0;
      empty = 1'b0;
      at = 0;
      steps = 0;
      if (beat.action != lphm_pkg::ACT_NOP) begin
        hit = find_slot(k, at, empty, steps);
        if (steps > longest_probe) longest_probe = steps;
      end
      case (beat.action)
        lphm_pkg::ACT_PUT: begin
          n_put++;
          if (hit) begin
            slot_val[at] = beat.value;
          end else if (used_count * 2 >= SLOTS || !empty) begin
            reply.status = lphm_pkg::ST_FULL;
            n_full++;
          end else begin
            slot_key[at] = k;
            slot_val[at] = beat.value;
            slot_used[at] = 1'b1;
            used_count++;
          end
        end
        lphm_pkg::ACT_GET: begin
          n_get++;
          if (hit) begin
            reply.result_value = slot_val[at];
          end else begin
            reply.status = lphm_pkg::ST_MISS;
            n_miss++;
          end
        end
        lphm_pkg::ACT_HAS: begin
          n_has++;
          if (!hit) begin
            reply.status = lphm_pkg::ST_MISS;
            n_miss++;
          end
        end
        default: n_nop++;
      endcase
      reply.entry_count = used_count[lphm_pkg::COUNT_W-1:0];
      expected_replies.push_back(reply);
    endtask

    task check_response(lphm_pkg::out_t got);
      lphm_pkg::out_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("result beat with nothing outstanding: %h", got));
        return;
      end
      want = expected_replies.pop_front();
      n_checked++;
      if (got.result_value !== want.result_value)
        report($sformatf("result_value %h, expected %h",
                         got.result_value, want.result_value));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, expected %0d",
                         got.entry_count, want.entry_count));
    endtask

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  lphm_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  lphm_pkg::out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  kv_table_tracker #(TABLE_SLOTS) tracker;
  logic [63:0] known_keys [$];

  linear_probe_hash_map #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_request(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_response(out_data);
  end

  initial begin
    #60ms;
    $display("timeout: %0d results still outstanding", tracker.pending());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  task automatic send_op(lphm_pkg::action_t act, logic [63:0] k, logic [63:0] v);
    lphm_pkg::in_t beat;
    beat.action = act;
    beat.key = k;
    beat.value = v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == lphm_pkg::ACT_PUT) known_keys.push_back(k);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int unsigned pick;
    logic [63:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      k = rand64();
      // some keys pile up near the top slot so that probe runs wrap
      if ($urandom_range(0, 9) == 0)
        while (tracker.home_of(k) < TABLE_SLOTS - 8) k = rand64();
      send_op(lphm_pkg::ACT_PUT, k, rand64());
    end else if (pick < 68) begin
      send_op(lphm_pkg::ACT_PUT, pick_known(), rand64());
    end else if (pick < 80) begin
      send_op(lphm_pkg::ACT_GET, pick_known(), rand64());
    end else if (pick < 85) begin
      send_op(lphm_pkg::ACT_GET, rand64(), rand64());
    end else if (pick < 92) begin
      send_op(lphm_pkg::ACT_HAS, pick_known(), rand64());
    end else if (pick < 97) begin
      send_op(lphm_pkg::ACT_HAS, rand64(), rand64());
    end else begin
      send_op(lphm_pkg::ACT_NOP, rand64(), rand64());
    end
  endtask

  initial begin
    logic [63:0] top_keys [4];
    logic [63:0] kmin, kmax;
    kmin = 64'h8000_0000_0000_0000;
    kmax = 64'h7fff_ffff_ffff_ffff;
    tracker = new();
    // four random keys that all hash to the last slot
    foreach (top_keys[i]) begin
      top_keys[i] = rand64();
      while (tracker.home_of(top_keys[i]) != TABLE_SLOTS - 1) top_keys[i] = rand64();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_stall_pct = 69;
    send_op(lphm_pkg::ACT_GET, 64'd0, kmax);
    send_op(lphm_pkg::ACT_HAS, kmax, 64'd0);
    send_op(lphm_pkg::ACT_PUT, kmin, kmax);
    send_op(lphm_pkg::ACT_PUT, kmax, kmin);
    send_op(lphm_pkg::ACT_PUT, 64'd0, '1);
    send_op(lphm_pkg::ACT_PUT, '1, 64'd0);
    send_op(lphm_pkg::ACT_GET, kmin, 64'd0);
    send_op(lphm_pkg::ACT_GET, kmax, '1);
    send_op(lphm_pkg::ACT_HAS, 64'd0, 64'd0);
    send_op(lphm_pkg::ACT_PUT, kmax, 64'h5555_aaaa_5555_aaaa);
    send_op(lphm_pkg::ACT_GET, kmax, 64'd0);
    send_op(lphm_pkg::ACT_NOP, '1, '1);
    send_op(lphm_pkg::ACT_PUT, top_keys[0], 64'h0123_4567_89ab_cdef);
    send_op(lphm_pkg::ACT_PUT, top_keys[1], 64'hfedc_ba98_7654_3210);
    send_op(lphm_pkg::ACT_PUT, top_keys[2], 64'haaaa_5555_aaaa_5555);
    send_op(lphm_pkg::ACT_GET, top_keys[2], 64'd0);
    send_op(lphm_pkg::ACT_HAS, top_keys[1], 64'd0);
    send_op(lphm_pkg::ACT_GET, top_keys[3], 64'd0);
    send_op(lphm_pkg::ACT_HAS, top_keys[3], 64'd0);
    send_op(lphm_pkg::ACT_NOP, 64'd0, 64'd0);
    send_op(lphm_pkg::ACT_GET, '1, kmin);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_stall_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_BEATS / 3 + (phase == 2 ? RANDOM_BEATS % 3 : 0); n++)
        send_random_op();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));

    $display("covered %0d operations: %0d put, %0d get, %0d contains, %0d no-op; %0d checked",
             tracker.n_put + tracker.n_get + tracker.n_has + tracker.n_nop, tracker.n_put,
             tracker.n_get, tracker.n_has, tracker.n_nop, tracker.n_checked);
    $display("table held %0d entries; %0d puts refused full, %0d lookups missed, probe up to %0d",
             tracker.used_count, tracker.n_full, tracker.n_miss, tracker.longest_probe);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
